// ----- hdl/crc8fr_pkg.sv -----
`default_nettype none

package crc8fr_pkg;

   localparam logic [7:0] MAX_FRAME_BYTES = 8'd150;

   localparam logic [7:0] CRC_POLY   = 8'h8c;
   localparam logic [7:0] BYTE_CR    = 8'h0d;
   localparam logic [7:0] BYTE_LF    = 8'h0a;
   localparam logic [7:0] HDR_FIRST_RESET  = 8'h55;
   localparam logic [7:0] HDR_SECOND_RESET = 8'haa;

   localparam logic [1:0] CSR_HDR_FIRST  = 2'd0;
   localparam logic [1:0] CSR_HDR_SECOND = 2'd1;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_HEADER_ERR = 2'd1,
      ST_CHECK_ERR  = 2'd2,
      ST_SHORT      = 2'd3
   } status_type;

   typedef struct packed {
      status_type   status;
      logic [15:0]  left_speed;
      logic [15:0]  right_speed;
      logic [31:0]  angle_bits;
      logic [7:0]   control_flag;
   } frame_result_type;

   // reflected crc-8, one byte
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/crc8fr_parser.sv -----
`default_nettype none

module crc8fr_parser
   import crc8fr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       rx_byte,
   input  wire logic [7:0]       hdr_first,
   input  wire logic [7:0]       hdr_second,
   output logic                  frame_end,
   output frame_result_type      result
);

   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  len_ff, len_in;
   logic        hdr_good_ff, hdr_good_in;
   logic        chk_seen_ff, chk_seen_in;
   logic        chk_match_ff, chk_match_in;
   logic        last_cr_ff, last_cr_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] right_ff, right_in;
   logic [31:0] angle_ff, angle_in;
   logic [7:0]  flag_ff, flag_in;

   logic [7:0]  u_pos, u_crc, u_len, u_flag;
   logic        u_hdr_good, u_seen, u_match;
   logic [15:0] u_left, u_right;
   logic [31:0] u_angle;
   logic [8:0]  check_pos;
   logic [8:0]  flag_pos;

   assign frame_end = (rx_byte == BYTE_LF) && last_cr_ff;

   always_comb begin
      u_pos      = pos_ff;
      u_crc      = crc_ff;
      u_len      = len_ff;
      u_hdr_good = hdr_good_ff;
      u_seen     = chk_seen_ff;
      u_match    = chk_match_ff;
      u_left     = left_ff;
      u_right    = right_ff;
      u_angle    = angle_ff;
      u_flag     = flag_ff;
      check_pos  = 9'd3 + {1'b0, len_ff};
      flag_pos   = 9'd2 + {1'b0, len_ff};

      if (pos_ff < MAX_FRAME_BYTES) begin
         if ((pos_ff == 8'd0) && (rx_byte != hdr_first)) begin
            u_hdr_good = 1'b0;
         end
         if ((pos_ff == 8'd1) && (rx_byte != hdr_second)) begin
            u_hdr_good = 1'b0;
         end
         if (pos_ff == 8'd2) begin
            u_len = rx_byte;
         end
         check_pos = 9'd3 + {1'b0, u_len};
         flag_pos  = 9'd2 + {1'b0, u_len};

         if ({1'b0, pos_ff} < check_pos) begin
            u_crc = crc8_update(crc_ff, rx_byte);
         end else if ({1'b0, pos_ff} == check_pos) begin
            u_seen  = 1'b1;
            u_match = (rx_byte == crc_ff);
         end

         case (pos_ff)
            8'd3:    u_left[7:0]    = rx_byte;
            8'd4:    u_left[15:8]   = rx_byte;
            8'd5:    u_right[7:0]   = rx_byte;
            8'd6:    u_right[15:8]  = rx_byte;
            8'd7:    u_angle[7:0]   = rx_byte;
            8'd8:    u_angle[15:8]  = rx_byte;
            8'd9:    u_angle[23:16] = rx_byte;
            8'd10:   u_angle[31:24] = rx_byte;
            default: ;
         endcase

         if ((pos_ff >= 8'd3) && ({1'b0, pos_ff} == flag_pos)) begin
            u_flag = rx_byte;
         end

         u_pos = pos_ff + 8'd1;
      end
   end

   always_comb begin
      if (!u_hdr_good) begin
         result.status = ST_HEADER_ERR;
      end else if (!u_seen) begin
         result.status = ST_SHORT;
      end else if (!u_match) begin
         result.status = ST_CHECK_ERR;
      end else begin
         result.status = ST_OK;
      end
      if (result.status == ST_OK) begin
         result.left_speed   = u_left;
         result.right_speed  = u_right;
         result.angle_bits   = u_angle;
         result.control_flag = u_flag;
      end else begin
         result.left_speed   = '0;
         result.right_speed  = '0;
         result.angle_bits   = '0;
         result.control_flag = '0;
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      len_in       = len_ff;
      hdr_good_in  = hdr_good_ff;
      chk_seen_in  = chk_seen_ff;
      chk_match_in = chk_match_ff;
      last_cr_in   = last_cr_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      angle_in     = angle_ff;
      flag_in      = flag_ff;
      if (step && frame_end) begin
         pos_in       = '0;
         crc_in       = '0;
         len_in       = '0;
         hdr_good_in  = 1'b1;
         chk_seen_in  = 1'b0;
         chk_match_in = 1'b0;
         last_cr_in   = 1'b0;
         left_in      = '0;
         right_in     = '0;
         angle_in     = '0;
         flag_in      = '0;
      end else if (step) begin
         pos_in       = u_pos;
         crc_in       = u_crc;
         len_in       = u_len;
         hdr_good_in  = u_hdr_good;
         chk_seen_in  = u_seen;
         chk_match_in = u_match;
         last_cr_in   = (rx_byte == BYTE_CR);
         left_in      = u_left;
         right_in     = u_right;
         angle_in     = u_angle;
         flag_in      = u_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         crc_ff       <= '0;
         len_ff       <= '0;
         hdr_good_ff  <= 1'b1;
         chk_seen_ff  <= 1'b0;
         chk_match_ff <= 1'b0;
         last_cr_ff   <= 1'b0;
         left_ff      <= '0;
         right_ff     <= '0;
         angle_ff     <= '0;
         flag_ff      <= '0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         len_ff       <= len_in;
         hdr_good_ff  <= hdr_good_in;
         chk_seen_ff  <= chk_seen_in;
         chk_match_ff <= chk_match_in;
         last_cr_ff   <= last_cr_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         angle_ff     <= angle_in;
         flag_ff      <= flag_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/crc8fr_out_reg.sv -----
`default_nettype none

module crc8fr_out_reg
   import crc8fr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire frame_result_type  result,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic                   space,
   output frame_result_type       held
);

   logic             valid_ff, valid_in;
   frame_result_type data_ff, data_in;

   assign space     = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign held = data_ff;

endmodule

`default_nettype wire

// ----- hdl/crc8_frame_receiver_unit.sv -----
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_rx_byte
// rsp       out        rsp_valid/rsp_ready  rsp_frame_status, speeds, angle, flag
// csr       in         csr_valid/csr_ready  csr_index, csr_wdata
//
// one byte per cycle unless a frame-ending byte meets a result not yet taken;
// a byte passes the input register, its frame update is one pass of crc and field
// logic, and the LF of a CR LF pair loads the result register as it advances.
// reset is synchronous and returns the headers to 0x55 / 0xaa and clears the frame.
// a held result stalls only bytes that end a frame; csr writes always complete.
`default_nettype none

module crc8_frame_receiver_unit
   import crc8fr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_frame_status,
   output logic signed [15:0]      rsp_left_speed,
   output logic signed [15:0]      rsp_right_speed,
   output logic [31:0]             rsp_angle_bits,
   output logic [7:0]              rsp_control_flag,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [7:0]         csr_wdata
);

   logic [7:0]       hdr_first_ff, hdr_first_in;
   logic [7:0]       hdr_second_ff, hdr_second_in;
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff, in_byte_in;
   logic             advance;
   logic             frame_end;
   logic             out_space;
   logic             load;
   frame_result_type result;
   frame_result_type out_data;

   assign csr_ready = 1'b1;

   always_comb begin
      hdr_first_in  = hdr_first_ff;
      hdr_second_in = hdr_second_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HDR_FIRST:  hdr_first_in  = csr_wdata;
            CSR_HDR_SECOND: hdr_second_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_first_ff  <= HDR_FIRST_RESET;
         hdr_second_ff <= HDR_SECOND_RESET;
      end else begin
         hdr_first_ff  <= hdr_first_in;
         hdr_second_ff <= hdr_second_in;
      end
   end

   // a byte that does not end a frame never waits on the result side
   assign advance   = in_valid_ff && (out_space || !frame_end);
   assign req_ready = !in_valid_ff || advance;
   assign load      = advance && frame_end;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   crc8fr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .rx_byte    (in_byte_ff),
      .hdr_first  (hdr_first_ff),
      .hdr_second (hdr_second_ff),
      .frame_end  (frame_end),
      .result     (result)
   );

   crc8fr_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .result    (result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .space     (out_space),
      .held      (out_data)
   );

   assign rsp_frame_status = out_data.status;
   assign rsp_left_speed   = out_data.left_speed;
   assign rsp_right_speed  = out_data.right_speed;
   assign rsp_angle_bits   = out_data.angle_bits;
   assign rsp_control_flag = out_data.control_flag;

   a_err_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_frame_status != ST_OK)) |->
      ((rsp_left_speed == 16'sd0) && (rsp_right_speed == 16'sd0) &&
       (rsp_angle_bits == 32'd0) && (rsp_control_flag == 8'd0)))
      else $error("error result carries nonzero fields");

   a_load_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("frame end did not raise rsp_valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(load && rsp_valid && !rsp_ready))
      else $error("result register overwritten while held");

   a_plain_byte_flows: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !frame_end) |-> req_ready)
      else $error("non-final byte stalled the input");

endmodule

`default_nettype wire

// ----- tb/sv/crc8_frame_receiver_unit_tb.sv -----
`timescale 1ns / 100ps

module crc8_frame_receiver_unit_tb;
   import crc8fr_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES   = 250;
   localparam logic [7:0] FILL_BYTE = 8'h5a;

   typedef enum logic [1:0] {SEAL_NONE, SEAL_GOOD, SEAL_BAD} seal_type;

   typedef struct packed {
      logic [255:0]     bytes;
      logic [7:0]       count;
      seal_type         seal;
      logic [7:0]       pad;
      logic             typed;
      frame_result_type want;
   } frame_row_type;

   localparam frame_result_type BLANK       = '{ST_OK, 16'h0, 16'h0, 32'h0, 8'h0};
   localparam frame_result_type HEADER_FAIL = '{ST_HEADER_ERR, 16'h0, 16'h0, 32'h0, 8'h0};
   localparam frame_result_type CHECK_FAIL  = '{ST_CHECK_ERR, 16'h0, 16'h0, 32'h0, 8'h0};
   localparam frame_result_type SHORT_FAIL  = '{ST_SHORT, 16'h0, 16'h0, 32'h0, 8'h0};

   // bytes in arrival order, left to right; the fill goes in before the closing CR LF
   localparam frame_row_type FRAME_PLAN [17] = '{
      '{256'h55_aa_09_00_80_ff_7f_00_00_80_7f_ff_00_0d_0a, 8'd15, SEAL_GOOD, 8'd0, 1'b1,
        '{ST_OK, 16'h8000, 16'h7fff, 32'h7f800000, 8'hff}},
      '{256'h55_aa_09_ff_ff_00_00_ff_ff_ff_ff_00_00_0d_0a, 8'd15, SEAL_GOOD, 8'd0, 1'b1,
        '{ST_OK, 16'hffff, 16'h0000, 32'hffffffff, 8'h00}},
      '{256'h55_aa_00_00_0d_0a, 8'd6, SEAL_GOOD, 8'd0, 1'b0, BLANK},
      '{256'h55_aa_02_34_12_00_0d_0a, 8'd8, SEAL_GOOD, 8'd0, 1'b0, BLANK},
      '{256'h54_aa_00_00_0d_0a, 8'd6, SEAL_NONE, 8'd0, 1'b1, HEADER_FAIL},
      '{256'h55_ab_00_00_0d_0a, 8'd6, SEAL_NONE, 8'd0, 1'b1, HEADER_FAIL},
      '{256'h00_aa_20_0d_0a, 8'd5, SEAL_NONE, 8'd0, 1'b1, HEADER_FAIL},
      '{256'h55_aa_20_01_02_0d_0a, 8'd7, SEAL_NONE, 8'd0, 1'b1, SHORT_FAIL},
      '{256'h55_aa_01_33_00_0d_0a, 8'd7, SEAL_BAD, 8'd0, 1'b1, CHECK_FAIL},
      '{256'h0d_0a, 8'd2, SEAL_NONE, 8'd0, 1'b1, HEADER_FAIL},
      '{256'h55_aa_00_0d_0a, 8'd5, SEAL_NONE, 8'd0, 1'b0, BLANK},
      '{256'h55_aa_01_0d_0a, 8'd5, SEAL_NONE, 8'd0, 1'b0, BLANK},
      '{256'h55_aa_04_0a_0d_11_0d_00_0d_0a, 8'd10, SEAL_GOOD, 8'd0, 1'b0, BLANK},
      '{256'h55_aa_00_00_0d_0a, 8'd6, SEAL_GOOD, 8'd200, 1'b0, BLANK},
      '{256'h55_aa_ff_0d_0a, 8'd5, SEAL_NONE, 8'd200, 1'b1, SHORT_FAIL},
      '{256'h55_aa_92_0d_0a, 8'd5, SEAL_GOOD, 8'd147, 1'b0, BLANK},
      '{256'h55_aa_93_0d_0a, 8'd5, SEAL_GOOD, 8'd148, 1'b1, SHORT_FAIL}
   };

   localparam logic [7:0] PHASE_FIRST  [4] = '{8'h55, 8'h00, 8'hff, 8'h00};
   localparam logic [7:0] PHASE_SECOND [4] = '{8'haa, 8'hff, 8'h00, 8'h00};
   localparam int PHASE_SEND_IDLE [4] = '{0, 49, 0, 26};
   localparam int PHASE_RSP_STALL [4] = '{0, 0, 49, 26};

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_frame_status;
   logic signed [15:0] rsp_left_speed;
   logic signed [15:0] rsp_right_speed;
   logic [31:0]        rsp_angle_bits;
   logic [7:0]         rsp_control_flag;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = CSR_HDR_FIRST;
   logic [7:0]         csr_wdata = 8'h00;

   crc8_frame_receiver_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_status (rsp_frame_status),
      .rsp_left_speed   (rsp_left_speed),
      .rsp_right_speed  (rsp_right_speed),
      .rsp_angle_bits   (rsp_angle_bits),
      .rsp_control_flag (rsp_control_flag),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // frame tracker state
   logic [7:0]  want_first, want_second;
   logic [7:0]  frame_pos, frame_crc, frame_len;
   logic        header_ok, check_seen, check_ok, prev_cr;
   logic [15:0] cap_left, cap_right;
   logic [31:0] cap_angle;
   logic [7:0]  cap_flag;

   frame_result_type frames_pending [$];
   frame_result_type head;
   logic [7:0]       burst [$];
   int               failures = 0;
   int               cycle_count = 0;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;
   logic             rsp_hold = 1'b0;
   event             hold_start;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);

   initial begin
      forever begin
         @(hold_start);
         rsp_hold = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold = 1'b0;
      end
   end

   function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] value);
      logic [7:0] r;
      r = acc ^ value;
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic void restart_frame();
      frame_pos  = '0;
      frame_crc  = '0;
      frame_len  = '0;
      header_ok  = 1'b1;
      check_seen = 1'b0;
      check_ok   = 1'b0;
      cap_left   = '0;
      cap_right  = '0;
      cap_angle  = '0;
      cap_flag   = '0;
   endfunction

   function automatic logic absorb_byte(input logic [7:0] value, output frame_result_type res);
      int where;
      int check_at;
      res = BLANK;
      where = int'(frame_pos);
      if (where < int'(MAX_FRAME_BYTES)) begin
         if (where == 0 && value != want_first) header_ok = 1'b0;
         if (where == 1 && value != want_second) header_ok = 1'b0;
         if (where == 2) frame_len = value;
         check_at = 3 + int'(frame_len);
         if (where < check_at) begin
            frame_crc = crc_next(frame_crc, value);
         end else if (where == check_at) begin
            check_seen = 1'b1;
            check_ok = (value == frame_crc);
         end
         case (where)
            3: cap_left[7:0] = value;
            4: cap_left[15:8] = value;
            5: cap_right[7:0] = value;
            6: cap_right[15:8] = value;
            7, 8, 9, 10: cap_angle[8*(where-7) +: 8] = value;
            default: ;
         endcase
         if (where >= 3 && where == int'(frame_len) + 2) cap_flag = value;
         frame_pos = frame_pos + 8'd1;
      end
      if (value != BYTE_LF || !prev_cr) begin
         prev_cr = (value == BYTE_CR);
         return 1'b0;
      end
      if (!header_ok) res.status = ST_HEADER_ERR;
      else if (!check_seen) res.status = ST_SHORT;
      else if (!check_ok) res.status = ST_CHECK_ERR;
      else res = '{ST_OK, cap_left, cap_right, cap_angle, cap_flag};
      prev_cr = 1'b0;
      restart_frame();
      return 1'b1;
   endfunction

   // puts the crc (or its inverse) at the check position of the frame in burst
   function automatic void seal_frame(input seal_type how);
      int spot;
      logic [7:0] acc;
      if (how == SEAL_NONE || burst.size() < 3) return;
      spot = 3 + int'(burst[2]);
      if (spot >= burst.size()) return;
      acc = '0;
      for (int i = 0; i < spot; i++) acc = crc_next(acc, burst[i]);
      burst[spot] = (how == SEAL_BAD) ? ~acc : acc;
   endfunction

   function automatic void build_random_frame();
      int len;
      int pick;
      seal_type how;
      burst.delete();
      if ($urandom_range(99) < 10) begin
         repeat ($urandom_range(20, 1))
            burst.push_back(($urandom_range(3) == 0) ?
                            (($urandom_range(1) == 0) ? BYTE_CR : BYTE_LF) : 8'($urandom));
         return;
      end
      pick = $urandom_range(99);
      if (pick < 80) len = $urandom_range(12);
      else if (pick < 95) len = $urandom_range(40, 13);
      else len = $urandom_range(255);
      burst.push_back(($urandom_range(99) < 90) ? want_first : 8'($urandom));
      burst.push_back(($urandom_range(99) < 90) ? want_second : 8'($urandom));
      burst.push_back(8'(len));
      repeat (len + 1) burst.push_back(8'($urandom));
      pick = $urandom_range(99);
      how = (pick < 85) ? SEAL_GOOD : (pick < 95) ? SEAL_BAD : SEAL_NONE;
      seal_frame(how);
      if ($urandom_range(99) < 8)
         repeat ($urandom_range(burst.size() - 1, 1)) void'(burst.pop_back());
      burst.push_back(BYTE_CR);
      burst.push_back(BYTE_LF);
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic typed,
                            input frame_result_type want);
      frame_result_type got;
      logic done;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      done = absorb_byte(value, got);
      if (done) frames_pending.push_back(typed ? want : got);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (frames_pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_HDR_FIRST) want_first = value;
      else if (index == CSR_HDR_SECOND) want_second = value;
      @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] expected,
                                input logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (frames_pending.size() == 0) begin
            $display("%0t: frame result with none pending, expected nothing, actual status %0d",
                     $time, rsp_frame_status);
            failures++;
         end else begin
            head = frames_pending.pop_front();
            compare_field("frame_status", 32'(head.status), 32'(rsp_frame_status));
            compare_field("left_speed", 32'(head.left_speed),
                          32'($unsigned(rsp_left_speed)));
            compare_field("right_speed", 32'(head.right_speed),
                          32'($unsigned(rsp_right_speed)));
            compare_field("angle_bits", head.angle_bits, rsp_angle_bits);
            compare_field("control_flag", 32'(head.control_flag), 32'(rsp_control_flag));
         end
      end
   end

   initial begin
      frame_row_type row;
      int sent;
      want_first = HDR_FIRST_RESET;
      want_second = HDR_SECOND_RESET;
      prev_cr = 1'b0;
      restart_frame();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames
      for (int r = 0; r < 17; r++) begin
         row = FRAME_PLAN[r];
         burst.delete();
         for (int k = 0; k < int'(row.count) - 2; k++)
            burst.push_back(row.bytes[8*(int'(row.count)-1-k) +: 8]);
         repeat (row.pad) burst.push_back(FILL_BYTE);
         burst.push_back(row.bytes[15:8]);
         burst.push_back(row.bytes[7:0]);
         seal_frame(row.seal);
         foreach (burst[k]) send_byte(burst[k], row.typed, row.want);
      end

      // random frames over several header settings and idle patterns
      for (int p = 0; p < 4; p++) begin
         settle();
         write_reg(CSR_HDR_FIRST, (p == 3) ? 8'($urandom) : PHASE_FIRST[p]);
         write_reg(CSR_HDR_SECOND, (p == 3) ? 8'($urandom) : PHASE_SECOND[p]);
         send_idle_pct = PHASE_SEND_IDLE[p];
         rsp_stall_pct = PHASE_RSP_STALL[p];
         if (p == 0) begin
            // receiver held off while empty frames keep coming
            -> hold_start;
            repeat (40) begin
               send_byte(BYTE_CR, 1'b0, BLANK);
               send_byte(BYTE_LF, 1'b0, BLANK);
            end
         end
         sent = 0;
         while (sent < PHASE_BYTES) begin
            build_random_frame();
            foreach (burst[k]) send_byte(burst[k], 1'b0, BLANK);
            sent += burst.size();
         end
      end

      settle();
      if (failures == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/crc8fr_pkg.sv
hdl/crc8fr_parser.sv
hdl/crc8fr_out_reg.sv
hdl/crc8_frame_receiver_unit.sv
tb/sv/crc8_frame_receiver_unit_tb.sv
